>>> design/enn_pkg.sv
package enn_pkg;

    // Table geometry.
    localparam int ENTRIES   = 64;
    localparam int DIM       = 128;
    localparam int ELEM_BITS = 16;

    localparam int SLOT_W  = $clog2(ENTRIES);
    localparam int CNT_W   = $clog2(ENTRIES + 1);
    localparam int EPOS_W  = $clog2(DIM + 1);
    localparam int EIDX_W  = $clog2(DIM);
    localparam int VADDR_W = $clog2(ENTRIES * DIM);
    localparam int DIFF_W  = ELEM_BITS + 1;
    localparam int SQ_W    = 2 * DIFF_W;
    localparam int DIST_W  = 40;
    localparam int SUM_W   = ((SQ_W > DIST_W) ? SQ_W : DIST_W) + 1;

    // Chain taps: the cells one and two places after the head, whose stored elements are read ahead.
    localparam int IDX1 = 1 % ENTRIES;
    localparam int IDX2 = 2 % ENTRIES;

    localparam logic [DIST_W-1:0] DIST_MAX = '1;

    // Operation codes.
    localparam logic [2:0] OP_ADD    = 3'd0;
    localparam logic [2:0] OP_QUERY  = 3'd1;
    localparam logic [2:0] OP_REMOVE = 3'd2;
    localparam logic [2:0] OP_FIND   = 3'd3;
    localparam logic [2:0] OP_CLEAR  = 3'd4;

    // Status codes.
    localparam logic [1:0] ST_OK      = 2'd0;
    localparam logic [1:0] ST_FULL    = 2'd1;
    localparam logic [1:0] ST_BAD_IDX = 2'd2;
    localparam logic [1:0] ST_MISSING = 2'd3;

    typedef struct packed {
        logic [2:0]         op;
        logic signed [15:0] element;
        logic               last;
        logic [5:0]         position;
        logic [31:0]        wanted_id;
    } t_in_item;

    typedef struct packed {
        logic [1:0]  status;
        logic        found;
        logic [5:0]  entry_position;
        logic [31:0] entry_id;
        logic [39:0] distance_sq;
        logic [6:0]  entry_count;
    } t_out_item;

    // Contents of one chain cell: vector slot, id and running distance.
    typedef struct packed {
        logic [SLOT_W-1:0] slot;
        logic [31:0]       id;
        logic [DIST_W-1:0] psum;
    } t_cell;

    // Control broadcast to every cell.
    typedef struct packed {
        logic              rot;
        logic              rem;
        logic              setid;
        logic [SLOT_W-1:0] pos;
        logic [SLOT_W-1:0] last_idx;
        logic [31:0]       id;
    } t_cell_ctl;

    typedef enum logic [2:0] {
        S_IDLE,
        S_ZFILL,
        S_PRIME0,
        S_PRIME1,
        S_ROT,
        S_EMIT
    } t_state;

    // Sign-extend the 16-bit input element and clamp it to ELEM_BITS.
    function automatic logic signed [ELEM_BITS-1:0] sat_elem(input logic signed [15:0] x);
        logic signed [32:0] v;
        logic signed [32:0] hi;
        logic signed [32:0] lo;
        v  = {{17{x[15]}}, x};
        hi = (33'sd1 <<< (ELEM_BITS - 1)) - 33'sd1;
        lo = -hi - 33'sd1;
        if (v > hi) begin
            v = hi;
        end
        if (v < lo) begin
            v = lo;
        end
        return v[ELEM_BITS-1:0];
    endfunction

    // Flat vector memory address of element e of slot s.
    function automatic logic [VADDR_W-1:0] vaddr(input logic [SLOT_W-1:0] s,
                                                 input logic [EIDX_W-1:0] e);
        logic [31:0] a;
        a = 32'(s) * 32'(DIM) + 32'(e);
        return a[VADDR_W-1:0];
    endfunction

endpackage

>>> design/enn_vmem.sv
module enn_vmem import enn_pkg::*; (
    input  logic                        i_clk,
    input  logic                        i_we,
    input  logic [VADDR_W-1:0]          i_waddr,
    input  logic signed [ELEM_BITS-1:0] i_wdata,
    input  logic [VADDR_W-1:0]          i_raddr,
    output logic signed [ELEM_BITS-1:0] o_rdata
);

    logic signed [ELEM_BITS-1:0] r_mem [ENTRIES*DIM];
    logic signed [ELEM_BITS-1:0] r_rdata;

    // One write port and one registered read port.
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

>>> design/enn_dist.sv
module enn_dist import enn_pkg::*; (
    input  logic                        i_clk,
    input  logic signed [ELEM_BITS-1:0] i_query,
    input  logic signed [ELEM_BITS-1:0] i_stored,
    output logic [SQ_W-1:0]             o_sq
);

    logic signed [DIFF_W-1:0] w_diff;
    logic [DIFF_W-1:0]        w_mag;
    logic [SQ_W-1:0]          r_sq;

    // Squared difference of one element pair, registered.
    always_comb begin
        w_diff = DIFF_W'(i_query) - DIFF_W'(i_stored);
        w_mag  = (w_diff < 0) ? DIFF_W'(-w_diff) : DIFF_W'(w_diff);
    end

    always_ff @(posedge i_clk) begin
        r_sq <= SQ_W'(w_mag) * SQ_W'(w_mag);
    end

    assign o_sq = r_sq;

endmodule

>>> design/enn_cell.sv
module enn_cell import enn_pkg::*; (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic [SLOT_W-1:0] i_idx,
    input  t_cell_ctl         i_ctl,
    input  t_cell             i_next,
    input  t_cell             i_ext,
    output t_cell             o_cell
);

    t_cell r_cell;

    // Each cell starts out owning the vector slot equal to its place in the chain.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cell.slot <= i_idx;
        end else if (i_ctl.rot) begin
            r_cell <= i_next;
        end else if (i_ctl.rem) begin
            // Later entries move up; the removed one parks after the last live entry.
            if (i_idx >= i_ctl.pos && i_idx < i_ctl.last_idx) begin
                r_cell <= i_next;
            end else if (i_idx == i_ctl.last_idx) begin
                r_cell <= i_ext;
            end
        end else if (i_ctl.setid && i_idx == i_ctl.last_idx) begin
            r_cell.id <= i_ctl.id;
        end
    end

    assign o_cell = r_cell;

endmodule

>>> design/embedding_nearest_neighbor_table.sv
// An add element that ends no embedding is written from S_IDLE and gives no item; a query
// element within DIM that ends none holds the input through S_PRIME0, S_PRIME1 and one chain turn.
// Ending an add zero-fills the rest of the entry in S_ZFILL, then gives its item through S_EMIT;
// remove, clear, a rejected add go straight to S_EMIT; a final query item or a find turns the chain first.
// Throughput: one item at a time; a query or find is set by one full turn of the cell chain
// through the single vector read port, one entry per cycle.
// Reset (synchronous, active low) empties the table and zeroes the id counter; no memory sweep.
module embedding_nearest_neighbor_table import enn_pkg::*; (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_in_valid,
    output logic      o_in_stall,
    input  t_in_item  i_in_item,
    output logic      o_out_valid,
    input  logic      i_out_stall,
    output t_out_item o_out_item
);

    t_state                      r_state, n_state;
    logic [CNT_W-1:0]            r_live, n_live;
    logic [31:0]                 r_idc, n_idc;
    logic [EPOS_W-1:0]           r_apos, n_apos;
    logic [EPOS_W-1:0]           r_qpos, n_qpos;
    logic [2:0]                  r_op, n_op;
    logic signed [ELEM_BITS-1:0] r_elem, n_elem;
    logic                        r_last, n_last;
    logic [31:0]                 r_wanted, n_wanted;
    logic                        r_upd, n_upd;
    logic                        r_first, n_first;
    logic [EIDX_W-1:0]           r_qidx, n_qidx;
    logic [SLOT_W-1:0]           r_step, n_step;
    logic [DIST_W-1:0]           r_best, n_best;
    logic [SLOT_W-1:0]           r_bpos, n_bpos;
    logic [31:0]                 r_bid, n_bid;
    logic                        r_fnd, n_fnd;
    t_out_item                   r_res, n_res;
    logic                        r_out_valid, n_out_valid;
    t_out_item                   r_out, n_out;

    t_cell                       w_cell [ENTRIES];
    t_cell                       w_tail;
    t_cell                       w_sel;
    t_cell_ctl                   w_ctl;
    logic [SLOT_W-1:0]           w_sel_idx;
    logic                        w_acc;
    logic signed [ELEM_BITS-1:0] w_elem_in;
    logic                        w_we;
    logic [VADDR_W-1:0]          w_waddr;
    logic signed [ELEM_BITS-1:0] w_wdata;
    logic [VADDR_W-1:0]          w_raddr;
    logic signed [ELEM_BITS-1:0] w_rdata;
    logic [SQ_W-1:0]             w_sq;
    logic                        w_hlive;
    logic [SUM_W-1:0]            w_sum;
    logic [DIST_W-1:0]           w_npsum;

    // Chain of cells; the tail takes the updated head during a turn.
    for (genvar g = 0; g < ENTRIES; g++) begin : g_cell
        if (g == ENTRIES - 1) begin : g_tail
            enn_cell u_cell (
                .i_clk   (i_clk),
                .i_rst_n (i_rst_n),
                .i_idx   (SLOT_W'(g)),
                .i_ctl   (w_ctl),
                .i_next  (w_tail),
                .i_ext   (w_sel),
                .o_cell  (w_cell[g])
            );
        end else begin : g_body
            enn_cell u_cell (
                .i_clk   (i_clk),
                .i_rst_n (i_rst_n),
                .i_idx   (SLOT_W'(g)),
                .i_ctl   (w_ctl),
                .i_next  (w_cell[g+1]),
                .i_ext   (w_sel),
                .o_cell  (w_cell[g])
            );
        end
    end

    enn_vmem u_vmem (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_waddr (w_waddr),
        .i_wdata (w_wdata),
        .i_raddr (w_raddr),
        .o_rdata (w_rdata)
    );

    enn_dist u_dist (
        .i_clk    (i_clk),
        .i_query  (r_elem),
        .i_stored (w_rdata),
        .o_sq     (w_sq)
    );

    assign w_acc      = i_in_valid && (r_state == S_IDLE);
    assign o_in_stall = (r_state != S_IDLE);
    assign w_elem_in  = sat_elem(i_in_item.element);

    // One selected cell: the removed entry, or the entry after the last live one.
    always_comb begin
        if (r_state == S_IDLE && i_in_item.op == OP_REMOVE) begin
            w_sel_idx = SLOT_W'(i_in_item.position);
        end else if (r_live < CNT_W'(ENTRIES)) begin
            w_sel_idx = r_live[SLOT_W-1:0];
        end else begin
            w_sel_idx = '0;
        end
        w_sel = w_cell[w_sel_idx];
    end

    // Head of the chain: saturating distance update.
    always_comb begin
        w_hlive = CNT_W'(r_step) < r_live;
        w_sum   = (r_first ? SUM_W'(0) : SUM_W'(w_cell[0].psum)) + SUM_W'(w_sq);
        if (r_upd && w_hlive) begin
            w_npsum = (w_sum > SUM_W'(DIST_MAX)) ? DIST_MAX : w_sum[DIST_W-1:0];
        end else begin
            w_npsum = w_cell[0].psum;
        end
        w_tail      = w_cell[0];
        w_tail.psum = w_npsum;
    end

    // Sequencer: next state, memory ports, cell control and results.
    always_comb begin
        n_state  = r_state;
        n_live   = r_live;
        n_idc    = r_idc;
        n_apos   = r_apos;
        n_qpos   = r_qpos;
        n_op     = r_op;
        n_elem   = r_elem;
        n_last   = r_last;
        n_wanted = r_wanted;
        n_upd    = r_upd;
        n_first  = r_first;
        n_qidx   = r_qidx;
        n_step   = r_step;
        n_best   = r_best;
        n_bpos   = r_bpos;
        n_bid    = r_bid;
        n_fnd    = r_fnd;
        n_res    = r_res;
        n_out    = r_out;
        n_out_valid = r_out_valid && i_out_stall;
        w_we     = 1'b0;
        w_waddr  = vaddr(w_sel.slot, EIDX_W'(r_apos));
        w_wdata  = '0;
        w_raddr  = vaddr(w_cell[0].slot, r_qidx);
        w_ctl    = '0;

        case (r_state)
            S_IDLE: begin
                if (w_acc) begin
                    n_op     = i_in_item.op;
                    n_elem   = w_elem_in;
                    n_last   = i_in_item.last;
                    n_wanted = i_in_item.wanted_id;
                    n_step   = '0;
                    n_fnd    = 1'b0;
                    n_res    = '0;
                    case (i_in_item.op)
                        OP_ADD: begin
                            if (r_live < CNT_W'(ENTRIES) && r_apos < EPOS_W'(DIM)) begin
                                w_we    = 1'b1;
                                w_wdata = w_elem_in;
                                n_apos  = r_apos + 1'b1;
                            end
                            if (i_in_item.last) begin
                                if (r_live >= CNT_W'(ENTRIES)) begin
                                    n_apos            = '0;
                                    n_res.status      = ST_FULL;
                                    n_res.entry_count = 7'(r_live);
                                    n_state           = S_EMIT;
                                end else begin
                                    n_state = S_ZFILL;
                                end
                            end
                        end
                        OP_QUERY: begin
                            if (r_qpos < EPOS_W'(DIM)) begin
                                n_upd   = 1'b1;
                                n_first = (r_qpos == '0);
                                n_qidx  = EIDX_W'(r_qpos);
                                n_qpos  = r_qpos + 1'b1;
                                n_state = S_PRIME0;
                            end else begin
                                n_upd = 1'b0;
                                if (i_in_item.last) begin
                                    n_state = S_PRIME0;
                                end
                            end
                        end
                        OP_REMOVE: begin
                            n_apos  = '0;
                            n_qpos  = '0;
                            n_state = S_EMIT;
                            if (CNT_W'(i_in_item.position) >= r_live) begin
                                n_res.status      = ST_BAD_IDX;
                                n_res.entry_count = 7'(r_live);
                            end else begin
                                w_ctl.rem            = 1'b1;
                                w_ctl.pos            = SLOT_W'(i_in_item.position);
                                w_ctl.last_idx       = SLOT_W'(r_live - 1'b1);
                                n_live               = r_live - 1'b1;
                                n_res.status         = ST_OK;
                                n_res.entry_position = i_in_item.position;
                                n_res.entry_id       = w_sel.id;
                                n_res.entry_count    = 7'(r_live - 1'b1);
                            end
                        end
                        OP_FIND: begin
                            n_upd   = 1'b0;
                            n_state = S_PRIME0;
                        end
                        OP_CLEAR: begin
                            n_live  = '0;
                            n_apos  = '0;
                            n_qpos  = '0;
                            n_state = S_EMIT;
                        end
                        default: begin
                        end
                    endcase
                end
            end

            // Zero the rest of the new entry, then give it the next id.
            S_ZFILL: begin
                if (r_apos < EPOS_W'(DIM)) begin
                    w_we   = 1'b1;
                    n_apos = r_apos + 1'b1;
                end else begin
                    n_idc             = r_idc + 32'd1;
                    w_ctl.setid       = 1'b1;
                    w_ctl.last_idx    = r_live[SLOT_W-1:0];
                    w_ctl.id          = r_idc + 32'd1;
                    n_live            = r_live + 1'b1;
                    n_apos            = '0;
                    n_qpos            = '0;
                    n_res             = '0;
                    n_res.entry_id    = r_idc + 32'd1;
                    n_res.entry_count = 7'(r_live + 1'b1);
                    n_state           = S_EMIT;
                end
            end

            // Fetch the stored elements of the first two entries before the turn starts.
            S_PRIME0: begin
                w_raddr = vaddr(w_cell[0].slot, r_qidx);
                n_state = S_PRIME1;
            end

            S_PRIME1: begin
                w_raddr = vaddr(w_cell[IDX1].slot, r_qidx);
                n_state = S_ROT;
            end

            // One turn of the chain: the head is updated and compared, then goes to the tail.
            S_ROT: begin
                w_raddr   = vaddr(w_cell[IDX2].slot, r_qidx);
                w_ctl.rot = 1'b1;
                n_step    = r_step + 1'b1;
                if (r_op == OP_QUERY && r_last && w_hlive &&
                    (r_step == '0 || w_npsum < r_best)) begin
                    n_best = w_npsum;
                    n_bpos = r_step;
                    n_bid  = w_cell[0].id;
                end
                if (r_op == OP_FIND && w_hlive && !r_fnd && w_cell[0].id == r_wanted) begin
                    n_fnd  = 1'b1;
                    n_bpos = r_step;
                end
                if (r_step == SLOT_W'(ENTRIES - 1)) begin
                    n_state = S_IDLE;
                    if (r_op == OP_FIND) begin
                        n_state = S_EMIT;
                        if (n_fnd) begin
                            n_res.status         = ST_OK;
                            n_res.found          = 1'b1;
                            n_res.entry_position = 6'(n_bpos);
                            n_res.entry_id       = r_wanted;
                        end else begin
                            n_res.status = ST_MISSING;
                        end
                        n_res.entry_count = 7'(r_live);
                    end else if (r_last) begin
                        n_qpos  = '0;
                        n_state = S_EMIT;
                        if (r_live == '0) begin
                            n_res.status = ST_MISSING;
                        end else begin
                            n_res.status         = ST_OK;
                            n_res.found          = 1'b1;
                            n_res.entry_position = 6'(n_bpos);
                            n_res.entry_id       = n_bid;
                            n_res.distance_sq    = n_best;
                            n_res.entry_count    = 7'(r_live);
                        end
                    end
                end
            end

            // Hand the result to the output register once it is free.
            S_EMIT: begin
                if (!r_out_valid || !i_out_stall) begin
                    n_out       = r_res;
                    n_out_valid = 1'b1;
                    n_state     = S_IDLE;
                end
            end

            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // Control registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_live      <= '0;
            r_idc       <= '0;
            r_apos      <= '0;
            r_qpos      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_live      <= n_live;
            r_idc       <= n_idc;
            r_apos      <= n_apos;
            r_qpos      <= n_qpos;
            r_out_valid <= n_out_valid;
        end
    end

    // Payload registers.
    always_ff @(posedge i_clk) begin
        r_op     <= n_op;
        r_elem   <= n_elem;
        r_last   <= n_last;
        r_wanted <= n_wanted;
        r_upd    <= n_upd;
        r_first  <= n_first;
        r_qidx   <= n_qidx;
        r_step   <= n_step;
        r_best   <= n_best;
        r_bpos   <= n_bpos;
        r_bid    <= n_bid;
        r_fnd    <= n_fnd;
        r_res    <= n_res;
        r_out    <= n_out;
    end

    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out;

endmodule

>>> design/enn_chk.sv
module enn_chk import enn_pkg::*; (
    input logic      i_clk,
    input logic      i_rst_n,
    input logic      i_in_valid,
    input logic      o_in_stall,
    input t_in_item  i_in_item,
    input logic      o_out_valid,
    input logic      i_out_stall,
    input t_out_item o_out_item
);

    // A stalled result stays offered.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid)
        else $error("result dropped while stalled");

    // A stalled result does not change.
    a_out_stable: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> $stable(o_out_item))
        else $error("result changed while stalled");

    // Only a good status can carry a found entry.
    a_found_ok: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out_item.found |-> o_out_item.status == ST_OK)
        else $error("found flag with bad status");

    // The live count never exceeds the table size.
    a_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> 32'(o_out_item.entry_count) <= ENTRIES)
        else $error("entry count above table size");

    // An accepted last query item or find item blocks the input on the next cycle.
    a_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && !o_in_stall && i_in_item.last &&
        (i_in_item.op == OP_QUERY || i_in_item.op == OP_FIND) |=> o_in_stall)
        else $error("input not held busy after a query or find");

endmodule

bind embedding_nearest_neighbor_table enn_chk u_enn_chk (.*);
